// ===== hw/rtl/delta_frame_encoder_front_defines.svh =====
// Assertion macros for the delta frame encoder front.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef DELTA_FRAME_ENCODER_FRONT_DEFINES_SVH
`define DELTA_FRAME_ENCODER_FRONT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DFE_ASSERT(lbl, prop, msg)
`define DFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dfe_pkg.sv =====
// Shared types and constants for the delta frame encoder front.
// No dependencies; imported by every module of the block.
package dfe_pkg;

    localparam int DFE_MAX_FRAME_BYTES = 1048576;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 21;
    localparam int FRAME_BYTES_W       = 21;
    localparam int QUEUE_DEPTH         = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFLATE_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_KEYFRAME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYFRAME_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES       = 3'd5;

    localparam logic ALG_DEFLATE   = 1'b1;
    localparam logic KEY_BIT_SET   = 1'b1;
    localparam logic KEY_BIT_CLEAR = 1'b0;

    typedef struct packed {
        logic                     algorithm;
        logic [3:0]               deflate_level;
        logic                     auto_keyframe;
        logic [7:0]               keyframe_interval;
        logic [2:0]               bytes_per_pixel;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] hdr1;
        logic [7:0] hdr2;
        logic       key;
        logic       fend;
        logic       first;
    } entry_t;

    typedef enum logic [1:0] {
        PH_HDR1,
        PH_HDR2,
        PH_DATA
    } phase_t;

endpackage

// ===== hw/rtl/dfe_front.sv =====
// Front part: accepts pixel bytes, tracks frame position and key decision,
// keeps the frame store and forms the delta. Depends on dfe_pkg.
module dfe_front
    import dfe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DFE_MAX_FRAME_BYTES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cfg_t                                cfg,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          pixel_byte,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
    output logic                                q_push,
    output entry_t                              q_wdata
);

    localparam int AW  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int CW  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LW  = (CW > FRAME_BYTES_W) ? CW : FRAME_BYTES_W;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]    store [0:MAX_FRAME_BYTES-1];

    logic [AW-1:0] pos_reg, pos_next;
    logic [7:0]    fsk_reg, fsk_next;
    logic          key_reg, key_next;
    logic          s1_valid_reg, s1_valid_next;
    entry_t        s1_reg;
    logic [7:0]    s1_byte_reg;
    logic [7:0]    rd_reg;

    logic          accept;
    logic [LW-1:0] len_raw, len, pos_inc;
    logic [AW-1:0] pos;
    logic          first, key, fend;
    logic [7:0]    interval, fsk_wrap;
    logic [8:0]    fsk_inc;
    logic [2:0]    bpp_m1;
    entry_t        s1_new;

    always_comb
    begin
        full     = ((QCW+1)'(q_count) + (QCW+1)'(s1_valid_reg)) >= (QCW+1)'(QUEUE_DEPTH);
        accept   = push && !full;

        len_raw  = LW'(cfg.frame_bytes);
        if (len_raw == '0)
            len = LW'(1);
        else if (len_raw > LW'(MAX_FRAME_BYTES))
            len = LW'(MAX_FRAME_BYTES);
        else
            len = len_raw;

        pos      = (LW'(pos_reg) >= len) ? '0 : pos_reg;
        first    = (pos == '0);
        key      = first ? ((fsk_reg == 8'd0) || !cfg.auto_keyframe) : key_reg;
        pos_inc  = LW'(pos) + LW'(1);
        fend     = (pos_inc >= len);

        interval = (cfg.keyframe_interval == 8'd0) ? 8'd1 : cfg.keyframe_interval;
        fsk_inc  = {1'b0, fsk_reg} + 9'd1;
        fsk_wrap = (fsk_inc >= {1'b0, interval}) ? 8'd0 : fsk_inc[7:0];

        bpp_m1         = cfg.bytes_per_pixel - 3'd1;
        s1_new.data    = 8'd0;
        s1_new.hdr1    = {(cfg.algorithm == ALG_DEFLATE) ? cfg.deflate_level : 4'd0,
                          2'b00, cfg.algorithm, key ? KEY_BIT_SET : KEY_BIT_CLEAR};
        s1_new.hdr2    = {4'd0, bpp_m1[1:0], 2'b00};
        s1_new.key     = key;
        s1_new.fend    = fend;
        s1_new.first   = first;

        pos_next      = pos_reg;
        fsk_next      = fsk_reg;
        key_next      = key_reg;
        s1_valid_next = accept;
        if (accept)
        begin
            key_next = key;
            if (fend)
            begin
                pos_next = '0;
                fsk_next = fsk_wrap;
            end
            else
            begin
                pos_next = pos_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fsk_reg      <= 8'd0;
            key_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            fsk_reg      <= fsk_next;
            key_reg      <= key_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // read-first store: the read sees every write of earlier cycles
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg      <= store[pos];
            store[pos]  <= pixel_byte;
            s1_reg      <= s1_new;
            s1_byte_reg <= pixel_byte;
        end
    end

    always_comb
    begin
        q_push       = s1_valid_reg;
        q_wdata      = s1_reg;
        q_wdata.data = s1_reg.key ? s1_byte_reg : (s1_byte_reg - rd_reg);
    end

endmodule

// ===== hw/rtl/dfe_queue.sv =====
// Short queue between the front and back parts.
// Depends on dfe_pkg for the entry type and depth.
module dfe_queue
    import dfe_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  entry_t                           wdata,
    input  logic                             pop,
    output entry_t                           head,
    output logic                             empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    entry_t         slots [0:QUEUE_DEPTH-1];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        if (push && !pop)
            count_next = count_reg + QCW'(1);
        else if (!push && pop)
            count_next = count_reg - QCW'(1);
        head  = slots[rd_ptr_reg];
        empty = (count_reg == '0);
        count = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== hw/rtl/dfe_back.sv =====
// Back part: expands each queued entry into header and data words.
// Depends on dfe_pkg.
module dfe_back
    import dfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  entry_t     q_head,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       is_header,
    output logic       key_frame,
    output logic       run_last,
    output logic       frame_end
);

    phase_t phase_reg, phase_next;
    logic   valid_reg, valid_next;
    entry_t entry_reg;
    logic   done;

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        done       = !valid_reg || (pop && phase_reg == PH_DATA);
        if (valid_reg && pop)
        begin
            case (phase_reg)
                PH_HDR1: phase_next = PH_HDR2;
                PH_HDR2: phase_next = PH_DATA;
                default: phase_next = phase_reg;
            endcase
        end
        q_pop = done && !q_empty;
        if (done)
        begin
            valid_next = !q_empty;
            if (!q_empty)
                phase_next = q_head.first ? PH_HDR1 : PH_DATA;
        end

        empty     = !valid_reg;
        key_frame = entry_reg.key;
        case (phase_reg)
            PH_HDR1:
            begin
                out_byte  = entry_reg.hdr1;
                is_header = 1'b1;
                run_last  = 1'b0;
                frame_end = 1'b0;
            end
            PH_HDR2:
            begin
                out_byte  = entry_reg.hdr2;
                is_header = 1'b1;
                run_last  = 1'b0;
                frame_end = 1'b0;
            end
            default:
            begin
                out_byte  = entry_reg.data;
                is_header = 1'b0;
                run_last  = 1'b1;
                frame_end = entry_reg.fend;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            entry_reg <= q_head;
    end

endmodule

// ===== hw/rtl/delta_frame_encoder_front.sv =====
// Top level of the delta frame encoder front: config registers, front part,
// queue and back part. Depends on dfe_pkg and the defines header.
//
// Pixel bytes of packed frames are pushed one per clock unless full is high;
// the block keeps the previous frame in an on-chip byte store (MAX_FRAME_BYTES
// deep, one read and one write per cycle, read data registered) and emits, per
// byte, the raw byte in a key frame or the byte minus the stored byte modulo 256
// in a delta frame. The first byte of every frame is preceded by two header
// words, so that byte yields three result words and every other byte yields
// one. Input takes one byte per cycle unless full; the result side drains one
// word per cycle while pop is high, so a frame of N bytes yields N + 2 words.
// A pushed byte passes the store stage, a queue slot and the back part's entry
// register before it reaches the result ports. The four-entry queue between
// the store stage and the header expander decouples the two sides: full rises
// when the queue plus the byte in flight fill it, so pushing continues while a
// finished word waits for pop. The store needs no clearing after reset; the
// first frame after reset is a key frame, and a delta frame must only read
// positions written earlier. Write the registers only while the block is idle.
module delta_frame_encoder_front
    import dfe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DFE_MAX_FRAME_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            pixel_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_byte,
    output logic                  is_header,
    output logic                  key_frame,
    output logic                  run_last,
    output logic                  frame_end
);

`include "delta_frame_encoder_front_defines.svh"

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cfg_t           cfg_reg, cfg_next;
    logic           q_push, q_pop, q_empty;
    entry_t         q_wdata, q_head;
    logic [QCW-1:0] q_count;

    // register file: index selects the field, upper data bits drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ALGORITHM:         cfg_next.algorithm         = cfg_data[0];
                CFG_DEFLATE_LEVEL:     cfg_next.deflate_level     = cfg_data[3:0];
                CFG_AUTO_KEYFRAME:     cfg_next.auto_keyframe     = cfg_data[0];
                CFG_KEYFRAME_INTERVAL: cfg_next.keyframe_interval = cfg_data[7:0];
                CFG_BYTES_PER_PIXEL:   cfg_next.bytes_per_pixel   = cfg_data[2:0];
                CFG_FRAME_BYTES:       cfg_next.frame_bytes       = cfg_data[FRAME_BYTES_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.algorithm         <= 1'b0;
            cfg_reg.deflate_level     <= 4'd6;
            cfg_reg.auto_keyframe     <= 1'b1;
            cfg_reg.keyframe_interval <= 8'd25;
            cfg_reg.bytes_per_pixel   <= 3'd3;
            cfg_reg.frame_bytes       <= 21'd1048576;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify, update the store and form the data word
    dfe_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .pixel_byte (pixel_byte),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // hold finished entries until the back part takes them
    dfe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty),
        .count (q_count)
    );

    // expand each entry into header and data words
    dfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .is_header (is_header),
        .key_frame (key_frame),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

    // the queue never runs past its depth
    `DFE_ASSERT(a_queue_bound, q_count <= QCW'(QUEUE_DEPTH), "queue count exceeds depth")
    // a header word is never the last word of its byte
    `DFE_ASSERT(a_hdr_not_last, !(!empty && is_header && (run_last || frame_end)), "header word marked last")
    // after a header word is taken, the rest of the run is already held
    `DFE_ASSERT_NEXT(a_hdr_run_held, pop && !empty && is_header, !empty, "run broken after header")
    // a push always finds room for the queue entry it creates
    `DFE_ASSERT_NEXT(a_no_overflow, push && !full, q_count < QCW'(QUEUE_DEPTH) || q_pop, "queue overflow")

endmodule
